/* rtl/core/sosc_pkg.sv */
// shared types and constants for the segmented odd prime sieve count core
// no dependencies
package sosc_pkg;
    localparam int MAX_LIMIT = 1048576;
    localparam int MAX_PARTS = 64;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LIMIT = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    localparam logic CFG_PART_COUNT = 1'b0;
    localparam logic CFG_PART_INDEX = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture limit and config, start square root
        logic div_start;  // start divider
        logic [2:0] div_op;
        logic sqrt_step;
        logic clr;        // clear both stores at addr
        logic small_init; // q = 3
        logic small_rd;
        logic small_mark;
        logic small_next;
        logic big_init;
        logic big_start;  // s = q*q
        logic big_mark;
        logic cnt_init;
        logic cnt_step;
        logic ptr_clr;
        logic ptr_inc;
        logic calc;       // first mark position from s, made odd
    } sosc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic ptr_end_clr;
        logic q2_over_r;  // small loop q*q > r
        logic q_over_r;
        logic small_marked;
        logic k_end_small;
        logic k_end_big;
        logic ptr_end_cnt;
        logic bad_limit;
        logic bad_index;
        logic bad_count;
        logic bad_share;
        logic sqrt_done;
        logic s_below_low; // q*q below the share base
    } sosc_sts_t;

    localparam logic [2:0] DOP_M_PC  = 3'd0; // m / pc
    localparam logic [2:0] DOP_LO    = 3'd1; // pi*m / pc
    localparam logic [2:0] DOP_HI    = 3'd2; // (pi+1)*m / pc
    localparam logic [2:0] DOP_CEIL  = 3'd3; // (low+q-1) / q
endpackage

/* rtl/core/sosc_ram.sv */
// generic single port ram with registered read
// no dependencies
module sosc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

/* rtl/core/sosc_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// no dependencies
module sosc_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic         done
);
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] r_reg, r_next;
    logic [W-1:0] d_reg, d_next;
    logic [$clog2(W+1)-1:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [W:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            n_next = ($clog2(W+1))'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == ($clog2(W+1))'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // quotient is final in the cycle that done is high
    assign quotient = q_reg;
    assign done = done_reg;
endmodule

/* rtl/core/sosc_datapath.sv */
// datapath: registers, divider, integer square root, mark stores, counter
// depends on sosc_pkg, sosc_ram, sosc_div
module sosc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sosc_pkg::sosc_cmd_t  cmd,
    output sosc_pkg::sosc_sts_t  sts,
    input  logic [20:0]          limit,
    input  logic [6:0]           part_count,
    input  logic [5:0]           part_index,
    output logic [19:0]          prime_total
);
    localparam int PW = 20;                 // positions
    localparam int SHARE_DEPTH = sosc_pkg::MAX_LIMIT / 2 + 1;
    localparam int AW = $clog2(SHARE_DEPTH);
    localparam int SMALL_DEPTH = 512;
    localparam int SAW = $clog2(SMALL_DEPTH);
    localparam int DW = 32;

    logic [20:0] n_reg;
    logic [6:0]  pc_reg;
    logic [5:0]  pi_reg;
    logic [19:0] m_reg;
    logic [10:0] r_reg;
    logic [10:0] rbit_reg;
    logic [19:0] ml_reg;     // m / pc
    logic [19:0] lo_reg;
    logic [19:0] size_reg;
    logic [10:0] q_reg;
    logic [20:0] k_reg;
    logic [AW-1:0] ptr_reg;
    logic [19:0] cnt_reg;
    logic        sdone_reg;
    logic [21:0] s_reg;
    logic [21:0] low_w;

    logic [DW-1:0] dvd, dvs, quo;
    logic div_done;
    logic sbit, bbit;
    logic s_we, b_we;
    logic [SAW-1:0] s_addr;
    logic [AW-1:0]  b_addr;
    logic [21:0] rtrial;

    assign low_w = {1'b0, lo_reg, 1'b0} + 22'd3;

    always_comb
    begin
        dvd = '0;
        dvs = DW'(pc_reg);
        case (cmd.div_op)
            sosc_pkg::DOP_M_PC: dvd = DW'(m_reg);
            sosc_pkg::DOP_LO:   dvd = DW'(pi_reg) * DW'(m_reg);
            sosc_pkg::DOP_HI:   dvd = (DW'(pi_reg) + 1) * DW'(m_reg);
            sosc_pkg::DOP_CEIL:
            begin
                dvd = DW'(low_w) + DW'(q_reg) - 1;
                dvs = DW'(q_reg);
            end
            default: dvd = '0;
        endcase
    end

    sosc_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(dvd), .divisor(dvs), .quotient(quo), .done(div_done)
    );

    // small store addressed by the pointer, k or q index; share store by k or the pointer
    always_comb
    begin
        s_we = cmd.clr || cmd.small_mark;
        if (cmd.clr)
            s_addr = ptr_reg[SAW-1:0];
        else if (cmd.small_mark)
            s_addr = k_reg[SAW-1:0];
        else
            s_addr = SAW'((q_reg - 11'd3) >> 1);
        b_we = cmd.clr || cmd.big_mark;
        b_addr = cmd.big_mark ? k_reg[AW-1:0] : ptr_reg;
    end

    sosc_ram #(.WIDTH(1), .DEPTH(SMALL_DEPTH)) u_small (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(cmd.small_mark), .rdata(sbit)
    );
    sosc_ram #(.WIDTH(1), .DEPTH(SHARE_DEPTH)) u_share (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(cmd.big_mark), .rdata(bbit)
    );

    assign rtrial = {11'd0, r_reg | rbit_reg} * {11'd0, r_reg | rbit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            pc_reg <= '0;
            pi_reg <= '0;
            m_reg <= '0;
            r_reg <= '0;
            rbit_reg <= '0;
            ml_reg <= '0;
            lo_reg <= '0;
            size_reg <= '0;
            ptr_reg <= '0;
            s_reg <= '0;
            cnt_reg <= '0;
            q_reg <= 11'd3;
            k_reg <= '0;
            sdone_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg <= limit;
                pc_reg <= part_count;
                pi_reg <= part_index;
                m_reg <= PW'((limit - 21'd1) >> 1);
                r_reg <= '0;
                rbit_reg <= 11'h400;
                sdone_reg <= 1'b0;
            end
            if (cmd.sqrt_step)
            begin
                if (rtrial <= {1'b0, n_reg})
                    r_reg <= r_reg | rbit_reg;
                rbit_reg <= rbit_reg >> 1;
                if (rbit_reg == 11'd1)
                    sdone_reg <= 1'b1;
            end
            if (div_done)
            begin
                case (cmd.div_op)
                    sosc_pkg::DOP_M_PC: ml_reg <= quo[19:0];
                    sosc_pkg::DOP_LO:   lo_reg <= quo[19:0];
                    sosc_pkg::DOP_HI:   size_reg <= quo[19:0] - lo_reg;
                    // ceil multiple of q at or above the share base
                    sosc_pkg::DOP_CEIL: s_reg <= 22'(quo[21:0] * {11'd0, q_reg});
                    default: ;
                endcase
            end
            if (cmd.ptr_clr)
                ptr_reg <= '0;
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + 1'b1;
            if (cmd.small_init || cmd.big_init)
                q_reg <= 11'd3;
            if (cmd.small_next)
                q_reg <= q_reg + 11'd2;
            if (cmd.small_rd)
                k_reg <= 21'(({10'd0, q_reg} * {10'd0, q_reg} - 21'd3) >> 1);
            if (cmd.small_mark || cmd.big_mark)
                k_reg <= k_reg + 21'(q_reg);
            if (cmd.big_start)
                s_reg <= 22'({11'd0, q_reg} * {11'd0, q_reg});
            // an even multiple steps on to the next odd one
            if (cmd.calc)
            begin
                if (s_reg[0])
                    k_reg <= 21'((s_reg - low_w) >> 1);
                else
                    k_reg <= 21'((s_reg + 22'(q_reg) - low_w) >> 1);
            end
            if (cmd.cnt_init)
                cnt_reg <= (pi_reg == 6'd0) ? 20'd1 : 20'd0;
            if (cmd.cnt_step && !bbit)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        sts = '0;
        sts.div_done = div_done;
        sts.ptr_end_clr = (ptr_reg == AW'(SMALL_DEPTH - 1) && size_reg <= 20'(SMALL_DEPTH))
                          || ({{(PW+1-AW){1'b0}}, ptr_reg} + 21'd1 >= 21'(size_reg)
                              && ptr_reg >= AW'(SMALL_DEPTH - 1));
        sts.q2_over_r = ({11'd0, q_reg} * {11'd0, q_reg}) > {11'd0, r_reg};
        sts.q_over_r = q_reg > r_reg;
        sts.small_marked = sbit;
        sts.k_end_small = ({k_reg, 1'b0} + 22'd3 > {11'd0, r_reg})
                          || k_reg >= 21'(SMALL_DEPTH);
        sts.k_end_big = k_reg >= {1'b0, size_reg};
        sts.ptr_end_cnt = {{(21-AW){1'b0}}, ptr_reg} >= {1'b0, size_reg};
        sts.bad_limit = (n_reg < 21'd9) || (22'(n_reg) > 22'(sosc_pkg::MAX_LIMIT));
        sts.bad_index = {1'b0, pi_reg} >= pc_reg;
        sts.bad_count = 32'(pc_reg) > 32'(sosc_pkg::MAX_PARTS);
        sts.bad_share = ({1'b0, ml_reg, 1'b0} + 22'd3) < {11'd0, r_reg};
        sts.sqrt_done = sdone_reg;
        sts.s_below_low = s_reg < low_w;
    end

    assign prime_total = cnt_reg;
endmodule

/* rtl/core/sosc_ctrl.sv */
// controller state machine sequencing checks, clearing, sieving and counting
// depends on sosc_pkg
module sosc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sosc_pkg::sosc_sts_t sts,
    output sosc_pkg::sosc_cmd_t cmd,
    output logic                done,
    output logic [1:0]          status
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQRT  = 5'd1;
    localparam logic [4:0] S_CHK   = 5'd2;
    localparam logic [4:0] S_DMP   = 5'd3;
    localparam logic [4:0] S_CHK2  = 5'd4;
    localparam logic [4:0] S_DLO   = 5'd5;
    localparam logic [4:0] S_DHI   = 5'd6;
    localparam logic [4:0] S_CLR   = 5'd7;
    localparam logic [4:0] S_SQ    = 5'd8;
    localparam logic [4:0] S_SRD   = 5'd9;
    localparam logic [4:0] S_STST  = 5'd10;
    localparam logic [4:0] S_SMARK = 5'd11;
    localparam logic [4:0] S_BQ    = 5'd12;
    localparam logic [4:0] S_BRD   = 5'd13;
    localparam logic [4:0] S_BTST  = 5'd14;
    localparam logic [4:0] S_BST   = 5'd15;
    localparam logic [4:0] S_BDIV  = 5'd16;
    localparam logic [4:0] S_BMARK = 5'd17;
    localparam logic [4:0] S_CNT0  = 5'd18;
    localparam logic [4:0] S_CRD   = 5'd19;
    localparam logic [4:0] S_CNT   = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;
    localparam logic [4:0] S_ERR   = 5'd22;
    localparam logic [4:0] S_BCK   = 5'd23;

    logic [4:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       div_go_reg, div_go_next;

    always_comb
    begin
        state_next = state_reg;
        st_next = st_reg;
        div_go_next = 1'b0;
        cmd = '0;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SQRT;
                end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    cmd.sqrt_step = 1'b0;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.bad_limit)
                begin
                    st_next = sosc_pkg::ST_BAD_LIMIT;
                    state_next = S_ERR;
                end
                else if (sts.bad_index)
                begin
                    st_next = sosc_pkg::ST_BAD_INDEX;
                    state_next = S_ERR;
                end
                else if (sts.bad_count)
                begin
                    st_next = sosc_pkg::ST_TOO_MANY;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.div_op = sosc_pkg::DOP_M_PC;
                    cmd.div_start = 1'b1;
                    state_next = S_DMP;
                end
            end
            S_DMP:
            begin
                cmd.div_op = sosc_pkg::DOP_M_PC;
                if (sts.div_done)
                    state_next = S_CHK2;
            end
            S_CHK2:
            begin
                if (sts.bad_share)
                begin
                    st_next = sosc_pkg::ST_TOO_MANY;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.div_op = sosc_pkg::DOP_LO;
                    cmd.div_start = 1'b1;
                    state_next = S_DLO;
                end
            end
            S_DLO:
            begin
                cmd.div_op = sosc_pkg::DOP_LO;
                if (sts.div_done)
                    div_go_next = 1'b1;
                if (div_go_reg)
                begin
                    cmd.div_op = sosc_pkg::DOP_HI;
                    cmd.div_start = 1'b1;
                    state_next = S_DHI;
                end
            end
            S_DHI:
            begin
                cmd.div_op = sosc_pkg::DOP_HI;
                if (sts.div_done)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                cmd.ptr_inc = 1'b1;
                if (sts.ptr_end_clr)
                begin
                    cmd.small_init = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
                if (sts.q2_over_r)
                begin
                    cmd.big_init = 1'b1;
                    state_next = S_BQ;
                end
                else
                    state_next = S_SRD;
            S_SRD:
            begin
                cmd.small_rd = 1'b1;
                state_next = S_STST;
            end
            S_STST:
                if (sts.small_marked)
                begin
                    cmd.small_next = 1'b1;
                    state_next = S_SQ;
                end
                else
                    state_next = S_SMARK;
            S_SMARK:
                if (sts.k_end_small)
                begin
                    cmd.small_next = 1'b1;
                    state_next = S_SQ;
                end
                else
                    cmd.small_mark = 1'b1;
            S_BQ:
                if (sts.q_over_r)
                begin
                    cmd.cnt_init = 1'b1;
                    cmd.ptr_clr = 1'b1;
                    state_next = S_CRD;
                end
                else
                    state_next = S_BRD;
            S_BRD:
                state_next = S_BTST;
            S_BTST:
                if (sts.small_marked)
                begin
                    cmd.small_next = 1'b1;
                    state_next = S_BQ;
                end
                else
                begin
                    cmd.big_start = 1'b1;
                    state_next = S_BST;
                end
            S_BST:
            begin
                // q*q against low, else ceil division
                if (sts.s_below_low)
                begin
                    cmd.div_op = sosc_pkg::DOP_CEIL;
                    cmd.div_start = 1'b1;
                    state_next = S_BDIV;
                end
                else
                begin
                    cmd.calc = 1'b1;
                    state_next = S_BMARK;
                end
            end
            S_BDIV:
            begin
                cmd.div_op = sosc_pkg::DOP_CEIL;
                if (sts.div_done)
                    state_next = S_BCK;
            end
            S_BCK:
            begin
                cmd.calc = 1'b1;
                state_next = S_BMARK;
            end
            S_BMARK:
                if (sts.k_end_big)
                begin
                    cmd.small_next = 1'b1;
                    state_next = S_BQ;
                end
                else
                    cmd.big_mark = 1'b1;
            S_CRD:
                if (sts.ptr_end_cnt)
                    state_next = S_DONE;
                else
                    state_next = S_CNT;
            S_CNT:
            begin
                cmd.cnt_step = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next = S_CRD;
            end
            S_DONE:
            begin
                st_next = sosc_pkg::ST_OK;
                state_next = S_IDLE;
            end
            S_ERR:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg <= sosc_pkg::ST_OK;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg <= st_next;
            div_go_reg <= div_go_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE) || (state_reg == S_ERR);
    assign status = (state_reg == S_DONE) ? sosc_pkg::ST_OK : st_reg;
endmodule

/* rtl/core/segmented_odd_prime_sieve_count_core.sv */
// Counts the primes in one share of the odd numbers 3..limit with a segmented
// odd-only sieve. One run clears the mark stores over every share position (at
// least 512), sets up each sieving prime and then marks its multiples in turn,
// and reads every share position once when counting; the single share store
// port sets its pace. A result appears for one cycle with done high and
// cannot be stalled.
// depends on sosc_pkg, sosc_ctrl, sosc_datapath
module segmented_odd_prime_sieve_count_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [20:0] limit,
    output logic        done,
    output logic [19:0] prime_total,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    sosc_pkg::sosc_cmd_t cmd;
    sosc_pkg::sosc_sts_t sts;
    logic [6:0]  pc_reg;
    logic [5:0]  pi_reg;
    logic [19:0] total;
    logic [1:0]  st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 7'd1;
            pi_reg <= 6'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sosc_pkg::CFG_PART_COUNT)
                pc_reg <= cfg_data;
            else
                pi_reg <= cfg_data[5:0];
        end
    end

    sosc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sts(sts), .cmd(cmd), .done(done), .status(st)
    );

    sosc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .limit(limit),
        .part_count(pc_reg), .part_index(pi_reg), .prime_total(total)
    );

    assign status = st;
    assign prime_total = (st == sosc_pkg::ST_OK) ? total : 20'd0;
endmodule

/* rtl/core/sosc_checker.sv */
// port level checks for the sieve count core
// depends on sosc_pkg; bound to segmented_odd_prime_sieve_count_core
module sosc_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [19:0] prime_total,
    input logic [1:0]  status
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted start did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != sosc_pkg::ST_OK |-> prime_total == 20'd0)
        else $error("nonzero total on error");
endmodule

bind segmented_odd_prime_sieve_count_core sosc_port_checks u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .prime_total(prime_total), .status(status)
);

/* tb/sosc_checker.sv */
// result predictor and scoreboard for the segmented odd prime sieve count core
// watches the command, result and register write channels; depends on sosc_pkg
module sosc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [20:0] limit,
    input  logic        done,
    input  logic [19:0] prime_total,
    input  logic [1:0]  status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output int          errors,
    output int          pending
);
    localparam longint unsigned LIMIT_TOP = 1048576;
    localparam longint unsigned PARTS_TOP = 64;

    typedef struct packed {
        logic [19:0] total;
        logic [1:0]  code;
    } count_result_t;

    count_result_t    expected_counts[$];
    logic [6:0]       parts;
    logic [5:0]       share_sel;
    bit               share_struck[524289];
    bit               root_struck[32768];

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic count_result_t count_share(input logic [20:0] lim,
                                                  input logic [6:0] pc_in,
                                                  input logic [5:0] pi_in);
        count_result_t   res;
        longint unsigned n, pc, pi, m, r, lo, size, low, q, k, s, cnt;
        n = lim;
        pc = pc_in;
        pi = pi_in;
        res.total = '0;
        if (n < 9 || n > LIMIT_TOP)
        begin
            res.code = sosc_pkg::ST_BAD_LIMIT;
            return res;
        end
        if (pi >= pc)
        begin
            res.code = sosc_pkg::ST_BAD_INDEX;
            return res;
        end
        if (pc > PARTS_TOP)
        begin
            res.code = sosc_pkg::ST_TOO_MANY;
            return res;
        end
        m = (n - 1) / 2;
        r = floor_sqrt(n);
        // sieving primes must all fall inside part zero
        if (2 * (m / pc) + 3 < r)
        begin
            res.code = sosc_pkg::ST_TOO_MANY;
            return res;
        end
        lo = pi * m / pc;
        size = (pi + 1) * m / pc - lo;
        low = 2 * lo + 3;
        for (k = 0; k <= r; k++) root_struck[k] = 0;
        for (k = 0; k < size; k++) share_struck[k] = 0;
        for (q = 3; q * q <= r; q += 2)
        begin
            if (root_struck[(q - 3) / 2]) continue;
            for (k = (q * q - 3) / 2; 2 * k + 3 <= r; k += q) root_struck[k] = 1;
        end
        for (q = 3; q <= r; q += 2)
        begin
            if (root_struck[(q - 3) / 2]) continue;
            s = q * q;
            // first odd multiple at or above the share base
            if (s < low)
            begin
                s = ((low + q - 1) / q) * q;
                if (s[0] == 1'b0) s += q;
            end
            for (k = (s - low) / 2; k < size; k += q) share_struck[k] = 1;
        end
        cnt = 0;
        for (k = 0; k < size; k++) if (!share_struck[k]) cnt++;
        if (pi == 0) cnt++;
        res.total = cnt[19:0];
        res.code = sosc_pkg::ST_OK;
        return res;
    endfunction

    assign pending = expected_counts.size();

    always @(posedge clk or negedge rst_n)
    begin
        count_result_t want;
        if (!rst_n)
        begin
            parts <= 7'd1;
            share_sel <= 6'd0;
            errors <= 0;
            expected_counts.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sosc_pkg::CFG_PART_COUNT) parts <= cfg_data;
                else share_sel <= cfg_data[5:0];
            end
            if (start && !busy) expected_counts.push_back(count_share(limit, parts, share_sel));
            if (done)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: unexpected result total=%0d status=%0d",
                             $time, prime_total, status);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (want.total !== prime_total || want.code !== status)
                    begin
                        $display("%0t: expected total=%0d status=%0d, got total=%0d status=%0d",
                                 $time, want.total, want.code, prime_total, status);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb_segmented_odd_prime_sieve_count_core.sv */
// stimulus and verdict for the segmented odd prime sieve count core
// depends on sosc_pkg, sosc_checker and the core rtl
module tb_segmented_odd_prime_sieve_count_core;
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [20:0] limit;
    logic        done;
    logic [19:0] prime_total;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    int          errors;
    int          pending;
    bit          quiet_phase;

    segmented_odd_prime_sieve_count_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .limit(limit),
        .done(done), .prime_total(prime_total), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sosc_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .limit(limit),
        .done(done), .prime_total(prime_total), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    task automatic idle_gap();
        int n;
        n = quiet_phase ? 0 :
            ($urandom_range(0, 9) == 0 ? $urandom_range(20, 200) : $urandom_range(0, 3));
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            limit = 21'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // one command transfer; start stays high until the next call or gap
    task automatic run_count(input logic [20:0] lim);
        idle_gap();
        @(negedge clk);
        start = 1'b1;
        limit = lim;
        do @(posedge clk); while (busy);
    endtask

    // registers only change once every result is back
    task automatic write_reg(input logic idx, input logic [6:0] data);
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_share(input logic [6:0] pc, input logic [6:0] pi);
        write_reg(sosc_pkg::CFG_PART_COUNT, pc);
        write_reg(sosc_pkg::CFG_PART_INDEX, pi);
    endtask

    function automatic logic [20:0] pick_limit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5) return 21'($urandom_range(0, 8));
        if (sel < 10) return 21'($urandom_range(1048577, 2097151));
        if (sel < 14) return 21'($urandom_range(9, 131072));
        return 21'($urandom_range(9, 4000));
    endfunction

    initial
    begin
        #1000000000;
        $display("segmented_odd_prime_sieve_count_core: mismatch");
        $finish;
    end

    initial
    begin
        logic [6:0] pc;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        limit = '0;
        cfg_valid = 1'b0;
        cfg_index = sosc_pkg::CFG_PART_COUNT;
        cfg_data = '0;
        quiet_phase = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // limit range edges with a single share
        run_count(21'd0);
        run_count(21'd8);
        run_count(21'd9);
        run_count(21'd10);
        run_count(21'h1FFFFF);
        run_count(21'd1048577);
        run_count(21'd1048576);
        run_count(21'd1000);
        // part index not below count, with a zero count
        set_share(7'd0, 7'd0);
        run_count(21'd1000);
        // too many parts, by count and by share length; then a valid run in the last of 64 parts
        set_share(7'd65, 7'd0);
        run_count(21'd1000);
        set_share(7'd127, 7'd127);
        run_count(21'd1000);
        set_share(7'd64, 7'd63);
        run_count(21'd1000);
        run_count(21'd200000);
        // empty share in part zero, one position in part one, then the last of three parts
        set_share(7'd8, 7'd0);
        run_count(21'd9);
        set_share(7'd8, 7'd1);
        run_count(21'd9);
        set_share(7'd3, 7'd2);
        run_count(21'd500);
        run_count(21'd4001);

        for (int ph = 0; ph < 8; ph++)
        begin
            if ($urandom_range(0, 5) == 0) pc = 7'($urandom_range(0, 127));
            else pc = 7'($urandom_range(1, 64));
            if ($urandom_range(0, 5) == 0) set_share(pc, 7'($urandom));
            else set_share(pc, (pc == 0) ? 7'd0 : 7'($urandom_range(0, pc - 1)));
            quiet_phase = ($urandom_range(0, 3) == 0);
            repeat (11) run_count(pick_limit());
        end

        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("segmented_odd_prime_sieve_count_core: match");
        else
            $display("segmented_odd_prime_sieve_count_core: mismatch");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/sosc_pkg.sv
rtl/core/sosc_ram.sv
rtl/core/sosc_div.sv
rtl/core/sosc_datapath.sv
rtl/core/sosc_ctrl.sv
rtl/core/segmented_odd_prime_sieve_count_core.sv
rtl/core/sosc_checker.sv
tb/sosc_checker.sv
tb/tb_segmented_odd_prime_sieve_count_core.sv
